// ===== hdl/decimal_digit_range_counter_macros.svh =====
// Assertion macros shared by the digit range counter modules.
`ifndef DECIMAL_DIGIT_RANGE_COUNTER_MACROS_SVH
`define DECIMAL_DIGIT_RANGE_COUNTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDRC_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DDRC_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ddrc_pkg.sv =====
// Shared types, widths and the power-of-ten table for the digit range counter.
package ddrc_pkg;

	localparam int unsigned IN_W           = 27;
	localparam int unsigned DIG_W          = 4;
	localparam int unsigned OCC_W          = 30;
	localparam int unsigned CNT_W          = 32;
	localparam int unsigned NDIG_CAP       = 9;   // a 27-bit operand never needs more digits
	localparam int unsigned BCD_W          = NDIG_CAP * DIG_W;
	localparam int unsigned POS_W          = 4;
	localparam int unsigned RADIX          = 10;
	localparam int unsigned NUM_DIGITS     = RADIX;
	localparam int unsigned MAX_DIGITS_DEF = 8;
	localparam int unsigned FIFO_DEPTH_DEF = 2;

	typedef logic [IN_W-1:0]            val_t;
	typedef logic [DIG_W-1:0]           dig_t;
	typedef logic [CNT_W-1:0]           cnt_t;
	typedef dig_t [NDIG_CAP-1:0]        bcd_t;

	// One classified range, handed from front to back.
	typedef struct packed {
		val_t hi;
		val_t lo_m1;
		bcd_t hi_bcd;
		bcd_t lo_bcd;
		logic bad;
	} job_t;

	function automatic cnt_t pow10(input logic [POS_W-1:0] p);
		cnt_t r;
		case (p)
			4'd0:    r = 32'd1;
			4'd1:    r = 32'd10;
			4'd2:    r = 32'd100;
			4'd3:    r = 32'd1000;
			4'd4:    r = 32'd10000;
			4'd5:    r = 32'd100000;
			4'd6:    r = 32'd1000000;
			4'd7:    r = 32'd10000000;
			4'd8:    r = 32'd100000000;
			4'd9:    r = 32'd1000000000;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/decimal_digit_range_counter.sv =====
// Decimal digit range counter: per-digit occurrence counts over low..high.
// Front: a capture step, then one shift-and-add-3 step per operand bit.
// Back: a walk over every position of high, then of low-1, a pipeline drain, then ten results at one per pop.
// The front can take and convert a new range while the back is still counting the last one.
// Reset: arst_n low idles both halves and empties the job queue; in-flight items are dropped.
module decimal_digit_range_counter #(
	parameter int unsigned MAX_DIGITS = ddrc_pkg::MAX_DIGITS_DEF,
	parameter int unsigned FIFO_DEPTH = ddrc_pkg::FIFO_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [ddrc_pkg::IN_W-1:0]    range_low,
	input  logic [ddrc_pkg::IN_W-1:0]    range_high,
	output logic                         empty,
	input  logic                         pop,
	output logic [ddrc_pkg::DIG_W-1:0]   digit,
	output logic [ddrc_pkg::OCC_W-1:0]   occurrences,
	output logic                         bad_range,
	output logic                         last_digit
);
	import ddrc_pkg::*;

	// Front -> queue: clamped bounds, high and low-1, in both binary and BCD,
	// plus the empty-range flag.
	job_t job_in, job_head;
	logic job_push, job_full;
	logic job_pop, job_empty;

	// Clamp to 10^MAX_DIGITS - 1, lift a zero low bound to 1, flag low > high,
	// then convert high and low-1 to BCD one bit per cycle.
	ddrc_front #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.range_low  (range_low),
		.range_high (range_high),
		.job_push   (job_push),
		.job_full   (job_full),
		.job        (job_in)
	);

	// Lets the front convert the next item while the back is still counting
	// or its results wait to be popped.
	ddrc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.wr_data (job_in),
		.full    (job_full),
		.pop     (job_pop),
		.rd_data (job_head),
		.empty   (job_empty)
	);

	// Walks the decimal positions from the most significant down, first for
	// high then for low-1, adding or subtracting each position's share into
	// ten per-digit accumulators, then offers the ten counts in digit order.
	// An empty range reports zero counts with the error flag set.
	ddrc_back #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (job_head),
		.job_empty   (job_empty),
		.job_pop     (job_pop),
		.empty       (empty),
		.pop         (pop),
		.digit       (digit),
		.occurrences (occurrences),
		.bad_range   (bad_range),
		.last_digit  (last_digit)
	);

endmodule

// ===== hdl/ddrc_front.sv =====
// Front end: takes a range, clamps and checks it, converts high and low-1 to BCD.
module ddrc_front #(
	parameter int unsigned MAX_DIGITS = ddrc_pkg::MAX_DIGITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  ddrc_pkg::val_t   range_low,
	input  ddrc_pkg::val_t   range_high,
	output logic             job_push,
	input  logic             job_full,
	output ddrc_pkg::job_t   job
);
	import ddrc_pkg::*;

	localparam int unsigned NDIG      = (MAX_DIGITS < NDIG_CAP) ? MAX_DIGITS : NDIG_CAP;
	localparam cnt_t        TOP_WIDE  = pow10(POS_W'(NDIG)) - 32'd1;
	localparam val_t        TOP       = (NDIG < NDIG_CAP) ? TOP_WIDE[IN_W-1:0] : '1;
	localparam int unsigned STEP_W    = $clog2(IN_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(IN_W - 1);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_CONV = 2'd1;
	localparam logic [1:0] F_HOLD = 2'd2;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	val_t              hi_q, lo_q, hi_sh_q, lo_sh_q;
	bcd_t              hi_bcd_q, lo_bcd_q;
	logic              bad_q;

	val_t lo_sat, hi_sat, lo_adj, lo_m1;
	logic bad;
	logic take;

	// shift-and-add-3: adjust each digit, then shift one binary bit in
	function automatic bcd_t dd_step(input bcd_t b, input logic in_bit);
		bcd_t             a;
		logic [BCD_W:0]   t;
		for (int i = 0; i < NDIG_CAP; i++) begin
			a[i] = (b[i] >= DIG_W'(5)) ? b[i] + DIG_W'(3) : b[i];
		end
		t = {a, in_bit};
		return t[BCD_W-1:0];
	endfunction

	assign lo_sat = (range_low  > TOP) ? TOP : range_low;
	assign hi_sat = (range_high > TOP) ? TOP : range_high;
	assign lo_adj = (lo_sat == '0) ? IN_W'(1) : lo_sat;
	assign bad    = lo_adj > hi_sat;
	assign lo_m1  = lo_adj - IN_W'(1);

	assign full     = (state_q != F_IDLE);
	assign take     = (state_q == F_IDLE) && push;
	assign job_push = (state_q == F_HOLD);

	assign job.hi     = hi_q;
	assign job.lo_m1  = lo_q;
	assign job.hi_bcd = hi_bcd_q;
	assign job.lo_bcd = lo_bcd_q;
	assign job.bad    = bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push) begin
						state_q <= F_CONV;
						step_q  <= '0;
					end
				end
				F_CONV: begin
					if (step_q == LAST_STEP) begin
						state_q <= F_HOLD;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				F_HOLD: begin
					if (!job_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hi_q     <= hi_sat;
			lo_q     <= lo_m1;
			bad_q    <= bad;
			hi_sh_q  <= hi_sat;
			lo_sh_q  <= lo_m1;
			hi_bcd_q <= '0;
			lo_bcd_q <= '0;
		end else if (state_q == F_CONV) begin
			hi_bcd_q <= dd_step(hi_bcd_q, hi_sh_q[IN_W-1]);
			lo_bcd_q <= dd_step(lo_bcd_q, lo_sh_q[IN_W-1]);
			hi_sh_q  <= {hi_sh_q[IN_W-2:0], 1'b0};
			lo_sh_q  <= {lo_sh_q[IN_W-2:0], 1'b0};
		end
	end

endmodule

// ===== hdl/ddrc_fifo.sv =====
// Short job queue between the front and back ends.
`include "decimal_digit_range_counter_macros.svh"

module ddrc_fifo #(
	parameter int unsigned DEPTH = ddrc_pkg::FIFO_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ddrc_pkg::job_t wr_data,
	output logic           full,
	input  logic           pop,
	output ddrc_pkg::job_t rd_data,
	output logic           empty
);
	import ddrc_pkg::*;

	localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

	job_t              mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              wr_ok, rd_ok;

	assign wr_ok   = push && !full;
	assign rd_ok   = pop && !empty;
	assign full    = (fill_q == FILL_MAX);
	assign empty   = (fill_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_ok) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_ok, rd_ok})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	`DDRC_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FILL_MAX, "fifo overfilled")
	`DDRC_ASSERT_NXT(a_push_grows, clk, arst_n, wr_ok && !rd_ok, fill_q == $past(fill_q) + 1'b1, "fifo fill did not grow on push")
	`DDRC_ASSERT_NXT(a_pop_frees, clk, arst_n, rd_ok && !wr_ok, !full, "fifo still full after pop")

endmodule

// ===== hdl/ddrc_back.sv =====
// Back end: per-position digit counting over both bounds, then ten results.
`include "decimal_digit_range_counter_macros.svh"

module ddrc_back #(
	parameter int unsigned MAX_DIGITS = ddrc_pkg::MAX_DIGITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ddrc_pkg::job_t               job,
	input  logic                         job_empty,
	output logic                         job_pop,
	output logic                         empty,
	input  logic                         pop,
	output logic [ddrc_pkg::DIG_W-1:0]   digit,
	output logic [ddrc_pkg::OCC_W-1:0]   occurrences,
	output logic                         bad_range,
	output logic                         last_digit
);
	import ddrc_pkg::*;

	localparam int unsigned NDIG = (MAX_DIGITS < NDIG_CAP) ? MAX_DIGITS : NDIG_CAP;
	localparam logic [POS_W-1:0] POS_TOP  = POS_W'(NDIG - 1);
	localparam dig_t             DIG_LAST = DIG_W'(NUM_DIGITS - 1);

	localparam logic [1:0] B_IDLE  = 2'd0;
	localparam logic [1:0] B_RUN   = 2'd1;
	localparam logic [1:0] B_DRAIN = 2'd2;
	localparam logic [1:0] B_EMIT  = 2'd3;

	logic [1:0]       state_q;
	logic [POS_W-1:0] pos_q;
	logic             sel_q;      // 0: upper bound, 1: lower bound minus one
	dig_t             dig_q;
	val_t             as_q;       // above * 10^pos
	val_t             rem_q;      // n mod 10^(pos+1)
	logic             bad_q;

	logic vld_s1, neg_s1;
	dig_t cur_s1;
	val_t as_s1, s_s1, below_s1;

	logic vld_s2, neg_s2, nz_s2;
	dig_t cur_s2;
	cnt_t v0_s2, v1_s2, v2_s2, v3_s2;

	cnt_t acc_q [NUM_DIGITS];
	cnt_t term  [NUM_DIGITS];

	dig_t cur_d;
	cnt_t pow_cur, pow_nxt, prod_cur, prod_nxt;
	val_t below, as_next;
	logic start;
	cnt_t as_w, s_w, below_w;

	assign start   = (state_q == B_IDLE) && !job_empty;
	assign job_pop = (state_q == B_RUN) && sel_q && (pos_q == '0);

	assign cur_d    = sel_q ? job.lo_bcd[pos_q] : job.hi_bcd[pos_q];
	assign pow_cur  = pow10(pos_q);
	assign pow_nxt  = pow10(pos_q - 1'b1);
	assign prod_cur = CNT_W'(cur_d) * pow_cur;
	assign prod_nxt = CNT_W'(cur_d) * pow_nxt;
	assign below    = rem_q - prod_cur[IN_W-1:0];
	assign as_next  = as_q + prod_nxt[IN_W-1:0];

	assign as_w    = CNT_W'(as_s1);
	assign s_w     = CNT_W'(s_s1);
	assign below_w = CNT_W'(below_s1);

	// per-digit contribution of one position
	always_comb begin
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (d == 0) begin
				term[d] = !nz_s2 ? '0 : ((cur_s2 != '0) ? v0_s2 : v3_s2);
			end else if (cur_s2 > DIG_W'(d)) begin
				term[d] = v1_s2;
			end else if (cur_s2 == DIG_W'(d)) begin
				term[d] = v2_s2;
			end else begin
				term[d] = v0_s2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			pos_q   <= '0;
			sel_q   <= 1'b0;
			dig_q   <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			vld_s1 <= (state_q == B_RUN);
			vld_s2 <= vld_s1;
			case (state_q)
				B_IDLE: begin
					if (!job_empty) begin
						state_q <= B_RUN;
						pos_q   <= POS_TOP;
						sel_q   <= 1'b0;
					end
				end
				B_RUN: begin
					if (pos_q == '0) begin
						if (sel_q) begin
							state_q <= B_DRAIN;
						end else begin
							sel_q <= 1'b1;
							pos_q <= POS_TOP;
						end
					end else begin
						pos_q <= pos_q - 1'b1;
					end
				end
				B_DRAIN: begin
					if (!vld_s1 && !vld_s2) begin
						state_q <= B_EMIT;
						dig_q   <= '0;
					end
				end
				B_EMIT: begin
					if (pop) begin
						if (dig_q == DIG_LAST) begin
							state_q <= B_IDLE;
						end else begin
							dig_q <= dig_q + 1'b1;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			as_q  <= '0;
			rem_q <= job.hi;
		end else if (state_q == B_RUN) begin
			if (pos_q == '0) begin
				as_q  <= '0;
				rem_q <= job.lo_m1;
			end else begin
				as_q  <= as_next;
				rem_q <= below;
			end
			if (job_pop) begin
				bad_q <= job.bad;
			end
		end

		as_s1    <= as_q;
		s_s1     <= pow_cur[IN_W-1:0];
		below_s1 <= below;
		cur_s1   <= cur_d;
		neg_s1   <= sel_q;

		v0_s2  <= as_w;
		v1_s2  <= as_w + s_w;
		v2_s2  <= as_w + below_w + CNT_W'(1);
		v3_s2  <= as_w + below_w + CNT_W'(1) - s_w;
		nz_s2  <= (as_s1 != '0);
		cur_s2 <= cur_s1;
		neg_s2 <= neg_s1;

		if (start) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				acc_q[d] <= '0;
			end
		end else if (vld_s2) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				acc_q[d] <= neg_s2 ? acc_q[d] - term[d] : acc_q[d] + term[d];
			end
		end
	end

	assign empty       = (state_q != B_EMIT);
	assign digit       = dig_q;
	assign occurrences = bad_q ? '0 : acc_q[dig_q][OCC_W-1:0];
	assign bad_range   = bad_q;
	assign last_digit  = (dig_q == DIG_LAST);

	`DDRC_ASSERT_IMP(a_pop_has_job, clk, arst_n, job_pop, !job_empty, "job popped from empty queue")
	`DDRC_ASSERT_NXT(a_last_ends_run, clk, arst_n, pop && !empty && last_digit, empty, "results continue past digit nine")
	`DDRC_ASSERT_IMP(a_emit_drained, clk, arst_n, state_q == B_EMIT, !vld_s1 && !vld_s2, "results shown before pipeline drained")

endmodule

// ===== test/digit_tally_checker.sv =====
// Checker for the digit range counter: predicts per-digit tallies and compares results.
module digit_tally_checker #(
	parameter int unsigned MAX_DIGITS = ddrc_pkg::MAX_DIGITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic                       full,
	input  logic [ddrc_pkg::IN_W-1:0]  range_low,
	input  logic [ddrc_pkg::IN_W-1:0]  range_high,
	input  logic                       empty,
	input  logic                       pop,
	input  logic [ddrc_pkg::DIG_W-1:0] digit,
	input  logic [ddrc_pkg::OCC_W-1:0] occurrences,
	input  logic                       bad_range,
	input  logic                       last_digit,
	output int unsigned                mismatches,
	output int unsigned                outstanding
);
	import ddrc_pkg::*;

	typedef struct packed {
		dig_t             digit;
		logic [OCC_W-1:0] occ;
		logic             bad;
		logic             last;
	} tally_t;

	tally_t tally_q[$];

	// largest operand the block handles: MAX_DIGITS nines
	function automatic logic [63:0] operand_cap();
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < MAX_DIGITS && i < 19; i++)
			p = p * 64'd10;
		return p - 64'd1;
	endfunction

	// times digit d appears across 1..n, one decimal position at a time
	function automatic logic [63:0] tally_upto(input logic [63:0] n, input int unsigned d);
		logic [63:0] total;
		logic [63:0] scale;
		logic [63:0] above;
		logic [63:0] cur;
		logic [63:0] below;
		total = '0;
		scale = 64'd1;
		for (int pos = 0; pos < MAX_DIGITS && pos < 19 && scale <= n; pos++) begin
			above = n / scale / 64'd10;
			cur   = (n / scale) % 64'd10;
			below = n % scale;
			if (d != 0) begin
				total = total + above * scale;
				if (cur > d)
					total = total + scale;
				else if (cur == d)
					total = total + below + 64'd1;
			end else if (above != 0) begin
				// no leading zeros: the top position never holds a zero
				total = total + (above - 64'd1) * scale;
				if (cur > 0)
					total = total + scale;
				else
					total = total + below + 64'd1;
			end
			scale = scale * 64'd10;
		end
		return total;
	endfunction

	always @(posedge clk) begin : watch
		tally_t      want;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] occ;
		logic        bad;
		if (arst_n) begin
			// results first: one pushed at this edge cannot leave at the same edge
			if (pop && !empty) begin
				if (tally_q.size() == 0) begin
					$error("result for digit %0d with nothing expected", digit);
					mismatches++;
				end else begin
					want = tally_q.pop_front();
					if (digit !== want.digit) begin
						$error("digit: expected %0d, got %0d", want.digit, digit);
						mismatches++;
					end
					if (occurrences !== want.occ) begin
						$error("occurrences: expected %0d, got %0d", want.occ, occurrences);
						mismatches++;
					end
					if (bad_range !== want.bad) begin
						$error("bad_range: expected %0d, got %0d", want.bad, bad_range);
						mismatches++;
					end
					if (last_digit !== want.last) begin
						$error("last_digit: expected %0d, got %0d", want.last, last_digit);
						mismatches++;
					end
				end
			end
			if (push && !full) begin
				lo = 64'(range_low);
				hi = 64'(range_high);
				if (lo > operand_cap())
					lo = operand_cap();
				if (hi > operand_cap())
					hi = operand_cap();
				if (lo == 0)
					lo = 64'd1;
				bad = lo > hi;
				for (int d = 0; d < NUM_DIGITS; d++) begin
					occ = bad ? 64'd0 : tally_upto(hi, d) - tally_upto(lo - 64'd1, d);
					want.digit = dig_t'(d);
					want.occ   = occ[OCC_W-1:0];
					want.bad   = bad;
					want.last  = (d == NUM_DIGITS - 1);
					tally_q.push_back(want);
				end
			end
			outstanding = tally_q.size();
		end
	end

endmodule

// ===== test/tb.sv =====
// Testbench top for the digit range counter: stimulus, flow control and verdict.
module tb;
	import ddrc_pkg::*;

	// cycles with no item moving on either side before the run is declared hung;
	// the long output hold-off below stays well under it
	localparam int unsigned STALL_LIMIT = 3000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned PHASE_ITEMS = 50;
	localparam val_t        OPND_CAP    = val_t'(99999999);
	localparam val_t        OPND_ALL1   = '1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	val_t        range_low = '0;
	val_t        range_high = '0;
	logic        full;
	logic        empty;
	dig_t        digit;
	logic [OCC_W-1:0] occurrences;
	logic        bad_range;
	logic        last_digit;

	int unsigned mismatches;
	int unsigned outstanding;

	// flow-control knobs, in percent, changed per phase
	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	logic        squeeze_req = 1'b0;

	// what the run went through, for the closing summary
	int unsigned sent_items = 0;
	int unsigned sent_empty = 0;
	int unsigned sent_clipped = 0;
	int unsigned idle_cycles = 0;

	decimal_digit_range_counter u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.range_low   (range_low),
		.range_high  (range_high),
		.empty       (empty),
		.pop         (pop),
		.digit       (digit),
		.occurrences (occurrences),
		.bad_range   (bad_range),
		.last_digit  (last_digit)
	);

	digit_tally_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.range_low   (range_low),
		.range_high  (range_high),
		.empty       (empty),
		.pop         (pop),
		.digit       (digit),
		.occurrences (occurrences),
		.bad_range   (bad_range),
		.last_digit  (last_digit),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// Hang detector: counts cycles in which neither side moves an item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Result side. Pop is redrawn every cycle against the stall rate; once per run
	// a squeeze request holds pop low for a long stretch so the block backs up
	// and raises full while the sender keeps offering.
	initial begin : receiver
		logic squeezed;
		squeezed = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (squeeze_req && !squeezed) begin
				pop <= 1'b0;
				squeezed = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				pop <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Offer one range; returns at the edge where the item was taken.
	// Gaps are drawn before the item so they land at any point of the block's work.
	task automatic offer_range(input val_t lo, input val_t hi);
		while ($urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push       <= 1'b1;
		range_low  <= lo;
		range_high <= hi;
		do
			@(posedge clk);
		while (full);
		sent_items++;
		if (lo > OPND_CAP || hi > OPND_CAP)
			sent_clipped++;
		if ((lo > OPND_CAP ? OPND_CAP : (lo == 0 ? val_t'(1) : lo)) >
		    (hi > OPND_CAP ? OPND_CAP : hi))
			sent_empty++;
	endtask

	// Random value with a random number of decimal digits, 1 to 8.
	function automatic val_t any_magnitude();
		int unsigned ndig;
		int unsigned floor_v;
		int unsigned ceil_v;
		ndig    = $urandom_range(8, 1);
		floor_v = 1;
		for (int i = 1; i < ndig; i++)
			floor_v = floor_v * 10;
		ceil_v = floor_v * 10 - 1;
		return val_t'($urandom_range(ceil_v, floor_v));
	endfunction

	// One random range. Mostly proper ranges of mixed magnitude, then narrow
	// windows, reversed (empty) ranges, oversized bounds, zero low bounds and raw noise.
	task automatic offer_random();
		val_t a;
		val_t b;
		int unsigned pick;
		pick = $urandom_range(99);
		a = any_magnitude();
		b = any_magnitude();
		if (pick < 55) begin
			offer_range(a < b ? a : b, a < b ? b : a);
		end else if (pick < 67) begin
			// narrow window just below the upper bound, crossing digit boundaries often
			if (b > 50)
				offer_range(b - val_t'($urandom_range(50)), b);
			else
				offer_range(val_t'($urandom_range(b, 1)), b);
		end else if (pick < 77) begin
			offer_range(a < b ? b : a, a < b ? a : b);
		end else if (pick < 86) begin
			// one or both bounds past the eight-digit cap
			a = val_t'($urandom_range(OPND_ALL1, 100000000));
			case ($urandom_range(2))
				0:       offer_range(b, a);
				1:       offer_range(a, b);
				default: offer_range(a, val_t'($urandom_range(OPND_ALL1, 100000000)));
			endcase
		end else if (pick < 92) begin
			offer_range('0, ($urandom_range(3) == 0) ? val_t'(0) : b);
		end else begin
			offer_range(val_t'($urandom), val_t'($urandom));
		end
	endtask

	initial begin : stimulus
		val_t        dir_lo[18];
		val_t        dir_hi[18];
		int unsigned gap_by_phase[4];
		int unsigned stall_by_phase[4];

		dir_lo = '{
			1, 1, 1, 0, 0, 5, 1, 10, 100, 12345678,
			99999999, OPND_ALL1, 1, OPND_CAP, 100000000, OPND_ALL1, 90000000, 0
		};
		dir_hi = '{
			1, 9, 10, 0, 5, 4, 99999999, 100, 199, 87654321,
			99999999, OPND_ALL1, OPND_ALL1, 100000000, OPND_CAP, 1, 99999999, OPND_ALL1
		};
		gap_by_phase   = '{0, 62, 0, 15};
		stall_by_phase = '{0, 0, 62, 15};

		// reset held low from the start, released once
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single digits, decade edges, empty and zero-low ranges,
		// saturated bounds and all-zero / all-one operand bits
		foreach (dir_lo[i])
			offer_range(dir_lo[i], dir_hi[i]);

		for (int ph = 0; ph < 4; ph++) begin
			gap_pct   = gap_by_phase[ph];
			stall_pct = stall_by_phase[ph];
			// long output hold-off once, while the sender runs flat out
			if (ph == 0)
				squeeze_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// a run of back-to-back items inside idling phases too
				if (n == PHASE_ITEMS / 2) begin
					gap_pct   = 0;
					stall_pct = 0;
				end
				offer_random();
			end
		end
		push <= 1'b0;

		// drain: wait until every predicted result has been taken, then settle
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("Ran %0d ranges: %0d empty, %0d with bounds past eight digits.",
			sent_items, sent_empty, sent_clipped);
		$display("Flow control: free running, sparse input, stalled output, both, one long hold-off.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
